// File: rtl/tph_pkg.sv
// Shared types and constants for the timed position history block.
// Used by tph_ctrl, tph_dp and the timed_position_history top level.
`timescale 1ns / 1ps
package tph_pkg;

  localparam int TimeW  = 31;
  localparam int CoordW = 16;
  localparam int OutW   = 24;
  // |numerator| of an interpolation: 49-bit signed sum shifted by 8
  localparam int DivW    = 57;
  localparam int DivCntW = 6;
  localparam int RemW    = TimeW + 1;

  localparam logic [1:0] CmdClear = 2'd0;
  localparam logic [1:0] CmdAdd   = 2'd1;
  localparam logic [1:0] CmdQuery = 2'd2;
  localparam logic [1:0] CmdNop   = 2'd3;

  typedef struct packed {
    logic [TimeW-1:0]         t;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] x;
  } tph_entry_t;

  // controller -> datapath
  typedef struct packed {
    logic load_in;
    logic clear;
    logic res_clr;
    logic srch_init;
    logic rd_mid;
    logic rd_i;
    logic rd_prev;
    logic srch_upd;
    logic lat_b;
    logic res_b;
    logic lat_a;
    logic mul;
    logic sum_div;
    logic bar_mul;
    logic bar_sum;
    logic div_step;
    logic push;
    logic res_x;
    logic res_y;
    logic coord_y;
    logic out_load;
  } tph_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] cmd;
    logic       len_zero;
    logic       hit;
    logic       b_direct;
    logic       a_direct;
    logic       bar_ok;
    logic       div_done;
    logic       coord_y;
  } tph_sts_t;

endpackage

// File: rtl/tph_dp.sv
// Datapath of the timed position history: sample ring, search pointers,
// multipliers and a shared restoring divider. Depends on tph_pkg.
`timescale 1ns / 1ps
module tph_dp #(
  parameter int DEPTH      = 16,
  parameter int BARRIER_MS = 7
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  tph_pkg::tph_cmd_t       cmd_i,
  output tph_pkg::tph_sts_t       sts_o,
  input  logic [1:0]              in_cmd_i,
  input  tph_pkg::tph_entry_t     in_entry_i,
  output logic [2*tph_pkg::OutW-1:0] out_data_o,
  output logic [1:0]              out_user_o
);
  import tph_pkg::*;

  localparam int IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam longint unsigned MaxBar = 64'd2147483647 / BARRIER_MS;
  localparam int BarW = $clog2(MaxBar + 1);
  // barrier index by reciprocal multiplication, exact for every 31-bit time
  localparam int BarShift = TimeW + $clog2(BARRIER_MS);
  localparam longint unsigned BarMul =
    ((64'd1 << BarShift) + 64'(BARRIER_MS) - 64'd1) / 64'(BARRIER_MS);
  localparam logic [32:0] BarMulW = 33'(BarMul);

  tph_entry_t ring [DEPTH];
  tph_entry_t rd_q, b_q, a_q;
  logic [IdxW-1:0] rd_addr, wr_addr;
  logic            rd_en;

  logic [1:0]       cmd_q;
  logic [CoordW-1:0] in_x_q, in_y_q;
  logic [TimeW-1:0] t_q;
  logic [CntW-1:0]  count_q, i_q, len_q, half, mid;
  logic [IdxW-1:0]  oldest_q, rel_idx;
  logic [IdxW:0]    phys_sum;
  logic [BarW-1:0]  last_bar_q, bar_q;
  logic [46:0]      bar_lo_q;
  logic [47:0]      bar_hi_q;
  logic [63:0]      bar_prod;
  logic             coord_y_q;

  logic [TimeW-1:0] d_q, dt_q;
  logic signed [47:0] p1_d, p2_d, p1_q, p2_q;
  logic signed [48:0] sum_s;
  logic signed [CoordW-1:0] va, vb;
  logic signed [CoordW:0]   dv;

  logic [RemW-1:0]    rem_q, rem_sh, trial;
  logic [DivW-1:0]    quo_q, sq;
  logic [TimeW-1:0]   dsr_q;
  logic               neg_q;
  logic [DivCntW-1:0] dcnt_q;

  logic              res_found_q, res_stored_q;
  logic [OutW-1:0]   res_x_q, res_y_q;
  logic [2*OutW-1:0] out_data_q;
  logic [1:0]        out_user_q;

  assign half = len_q >> 1;
  assign mid  = i_q + half;

  always_comb begin
    rel_idx = i_q[IdxW-1:0];
    if (cmd_i.rd_mid) begin
      rel_idx = mid[IdxW-1:0];
    end else if (cmd_i.rd_prev) begin
      rel_idx = IdxW'(i_q - CntW'(1));
    end
    phys_sum = {1'b0, oldest_q} + {1'b0, rel_idx};
    if (phys_sum >= (IdxW+1)'(DEPTH)) begin
      phys_sum = phys_sum - (IdxW+1)'(DEPTH);
    end
    rd_addr = phys_sum[IdxW-1:0];
  end

  assign rd_en   = cmd_i.rd_mid | cmd_i.rd_i | cmd_i.rd_prev;
  assign wr_addr = (count_q < CntW'(DEPTH)) ? count_q[IdxW-1:0] : oldest_q;

  // ring storage, no reset: entries are read only after being written
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      ring[wr_addr] <= '{t: t_q, y: in_y_q, x: in_x_q};
    end
    if (rd_en) begin
      rd_q <= ring[rd_addr];
    end
  end

  assign va = coord_y_q ? a_q.y : a_q.x;
  assign vb = coord_y_q ? b_q.y : b_q.x;
  assign dv = {vb[CoordW-1], vb} - {va[CoordW-1], va};
  assign p1_d = va * $signed({1'b0, d_q});
  assign p2_d = $signed({1'b0, dt_q}) * dv;
  assign sum_s = {p1_q[47], p1_q} + {p2_q[47], p2_q};

  assign bar_prod = 64'(bar_lo_q) + {bar_hi_q, 16'h0000};

  assign rem_sh = {rem_q[RemW-2:0], quo_q[DivW-1]};
  assign trial  = rem_sh - {1'b0, dsr_q};
  assign sq     = neg_q ? (~quo_q + DivW'(1)) : quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      oldest_q   <= '0;
      last_bar_q <= '0;
      i_q        <= '0;
      len_q      <= '0;
      coord_y_q  <= 1'b0;
      dcnt_q     <= '0;
    end else begin
      if (cmd_i.clear) begin
        count_q  <= '0;
        oldest_q <= '0;
      end
      if (cmd_i.push) begin
        last_bar_q <= bar_q;
        if (count_q < CntW'(DEPTH)) begin
          count_q <= count_q + CntW'(1);
        end else if (oldest_q == IdxW'(DEPTH - 1)) begin
          oldest_q <= '0;
        end else begin
          oldest_q <= oldest_q + IdxW'(1);
        end
      end
      if (cmd_i.srch_init) begin
        i_q   <= '0;
        len_q <= count_q;
      end
      if (cmd_i.srch_upd) begin
        if (rd_q.t < t_q) begin
          i_q   <= mid + CntW'(1);
          len_q <= len_q - half - CntW'(1);
        end else begin
          len_q <= half;
        end
      end
      if (cmd_i.lat_a) begin
        coord_y_q <= 1'b0;
      end else if (cmd_i.coord_y) begin
        coord_y_q <= 1'b1;
      end
      if (cmd_i.sum_div) begin
        dcnt_q <= '0;
      end else if (cmd_i.div_step) begin
        dcnt_q <= dcnt_q + DivCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      cmd_q  <= in_cmd_i;
      in_x_q <= in_entry_i.x;
      in_y_q <= in_entry_i.y;
      t_q    <= in_entry_i.t;
    end
    // split the reciprocal product into two narrow multiplies
    if (cmd_i.bar_mul) begin
      bar_lo_q <= 47'(t_q) * 47'(BarMulW[15:0]);
      bar_hi_q <= 48'(t_q) * 48'(BarMulW[32:16]);
    end
    if (cmd_i.bar_sum) begin
      bar_q <= BarW'(bar_prod >> BarShift);
    end
    if (cmd_i.lat_b) begin
      b_q <= rd_q;
    end
    if (cmd_i.lat_a) begin
      a_q  <= rd_q;
      d_q  <= b_q.t - rd_q.t;
      dt_q <= t_q - rd_q.t;
    end
    if (cmd_i.mul) begin
      p1_q <= p1_d;
      p2_q <= p2_d;
    end
    if (cmd_i.sum_div) begin
      rem_q <= '0;
      quo_q <= sum_s[48] ? {~sum_s + 49'd1, 8'h00} : {sum_s, 8'h00};
      dsr_q <= d_q;
      neg_q <= sum_s[48];
    end else if (cmd_i.div_step) begin
      if (!trial[RemW-1]) begin
        rem_q <= trial;
        quo_q <= {quo_q[DivW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[DivW-2:0], 1'b0};
      end
    end
    if (cmd_i.res_clr) begin
      res_found_q  <= 1'b0;
      res_stored_q <= 1'b0;
      res_x_q      <= '0;
      res_y_q      <= '0;
    end
    if (cmd_i.push) begin
      res_stored_q <= 1'b1;
    end
    if (cmd_i.res_b) begin
      res_found_q <= 1'b1;
      res_x_q     <= {b_q.x, 8'h00};
      res_y_q     <= {b_q.y, 8'h00};
    end
    if (cmd_i.res_x) begin
      res_found_q <= 1'b1;
      res_x_q     <= sq[OutW-1:0];
    end
    if (cmd_i.res_y) begin
      res_y_q <= sq[OutW-1:0];
    end
    if (cmd_i.out_load) begin
      out_data_q <= {res_y_q, res_x_q};
      out_user_q <= {res_stored_q, res_found_q};
    end
  end

  assign out_data_o = out_data_q;
  assign out_user_o = out_user_q;

  assign sts_o.cmd      = cmd_q;
  assign sts_o.len_zero = (len_q == '0);
  assign sts_o.hit      = (i_q < count_q);
  assign sts_o.b_direct = (i_q == '0) || (rd_q.t <= t_q);
  assign sts_o.a_direct = (rd_q.t >= t_q);
  assign sts_o.bar_ok   = (count_q == '0) || (last_bar_q < bar_q);
  assign sts_o.div_done = (dcnt_q == DivCntW'(DivW));
  assign sts_o.coord_y  = coord_y_q;

endmodule

// File: rtl/tph_ctrl.sv
// Controller state machine of the timed position history: sequences decode,
// add, search, divide and result hand-off. Depends on tph_pkg.
`timescale 1ns / 1ps
module tph_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  input  tph_pkg::tph_sts_t sts_i,
  output tph_pkg::tph_cmd_t cmd_o
);
  import tph_pkg::*;

  localparam logic [3:0] StIdle   = 4'd0;
  localparam logic [3:0] StDecode = 4'd1;
  localparam logic [3:0] StBdiv   = 4'd2;
  localparam logic [3:0] StAddw   = 4'd3;
  localparam logic [3:0] StSrch   = 4'd4;
  localparam logic [3:0] StScmp   = 4'd5;
  localparam logic [3:0] StRdb    = 4'd6;
  localparam logic [3:0] StLatb   = 4'd7;
  localparam logic [3:0] StLata   = 4'd8;
  localparam logic [3:0] StMul    = 4'd9;
  localparam logic [3:0] StSum    = 4'd10;
  localparam logic [3:0] StIdiv   = 4'd11;
  localparam logic [3:0] StFin    = 4'd12;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  // sample b straight from the read port: the result uses the latched copy
  // in the next cycle, so hold res_b until after lat_b
  logic       res_b_q;

  assign s_ready_o = (state_q == StIdle);
  assign m_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (s_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = StDecode;
        end
      end
      StDecode: begin
        cmd_o.res_clr = 1'b1;
        unique case (sts_i.cmd)
          CmdClear: begin
            cmd_o.clear = 1'b1;
            state_d     = StFin;
          end
          CmdAdd: begin
            cmd_o.bar_mul = 1'b1;
            state_d       = StBdiv;
          end
          CmdQuery: begin
            cmd_o.srch_init = 1'b1;
            state_d         = StSrch;
          end
          CmdNop: state_d = StFin;
          default: state_d = StFin;
        endcase
      end
      StBdiv: begin
        cmd_o.bar_sum = 1'b1;
        state_d       = StAddw;
      end
      StAddw: begin
        cmd_o.push = sts_i.bar_ok;
        state_d    = StFin;
      end
      StSrch: begin
        if (sts_i.len_zero) begin
          state_d = StRdb;
        end else begin
          cmd_o.rd_mid = 1'b1;
          state_d      = StScmp;
        end
      end
      StScmp: begin
        cmd_o.srch_upd = 1'b1;
        state_d        = StSrch;
      end
      StRdb: begin
        if (sts_i.hit) begin
          cmd_o.rd_i = 1'b1;
          state_d    = StLatb;
        end else begin
          state_d = StFin;
        end
      end
      StLatb: begin
        cmd_o.lat_b = 1'b1;
        if (sts_i.b_direct) begin
          state_d = StFin;
        end else begin
          cmd_o.rd_prev = 1'b1;
          state_d       = StLata;
        end
      end
      StLata: begin
        cmd_o.lat_a = 1'b1;
        state_d     = sts_i.a_direct ? StFin : StMul;
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = StSum;
      end
      StSum: begin
        cmd_o.sum_div = 1'b1;
        state_d       = StIdiv;
      end
      StIdiv: begin
        if (!sts_i.div_done) begin
          cmd_o.div_step = 1'b1;
        end else if (sts_i.coord_y) begin
          cmd_o.res_y = 1'b1;
          state_d     = StFin;
        end else begin
          cmd_o.res_x   = 1'b1;
          cmd_o.coord_y = 1'b1;
          state_d       = StMul;
        end
      end
      StFin: begin
        cmd_o.res_b = res_b_q;
        if (!res_b_q && (!out_valid_q || m_ready_i)) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      res_b_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      res_b_q     <= ((state_q == StLatb) && sts_i.b_direct) ||
                     ((state_q == StLata) && sts_i.a_direct);
    end
  end

endmodule

// File: rtl/timed_position_history.sv
// Top level of the timed position history: stream ports, controller and
// datapath. Depends on tph_pkg, tph_ctrl and tph_dp.
//
// Usage: one command per input transfer on the s_axis channel, one result
// per command on the m_axis channel. tuser carries the command (clear, add,
// query, no-op); tdata carries pos_x, pos_y and time_ms. The result tuser
// carries found and stored, tdata the Q.8 x and y of a query.
// Work per command: clear and no-op go straight to the result, and an add
// first forms its barrier index by a reciprocal multiply split into a
// multiply step and a sum step. A query runs k search steps, k at most
// ceil(log2(count+1)), and then finds nothing, returns a sample as stored
// (after checking its older neighbour where needed) or interpolates with
// two passes through the 57-step restoring divider.
// The block takes one command at a time; the result sits in an output
// register, so the next command is taken while a result waits. A stalled
// receiver holds the result and, after the next command is worked, the
// block waits before replacing it.
// Reset empties the ring and clears both channels; no clearing pass.
`timescale 1ns / 1ps
module timed_position_history #(
  parameter int DEPTH      = 16,
  parameter int BARRIER_MS = 7
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // pos_x[15:0], pos_y[31:16], time_ms[62:32]
  input  logic [1:0]  s_axis_tuser,  // cmd[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // x_out[23:0], y_out[47:24]
  output logic [1:0]  m_axis_tuser   // found[0], stored[1]
);
  import tph_pkg::*;

  tph_cmd_t   cmd;
  tph_sts_t   sts;
  tph_entry_t in_entry;

  assign in_entry.x = s_axis_tdata[15:0];
  assign in_entry.y = s_axis_tdata[31:16];
  assign in_entry.t = s_axis_tdata[62:32];

  tph_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  tph_dp #(
    .DEPTH      (DEPTH),
    .BARRIER_MS (BARRIER_MS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_cmd_i   (s_axis_tuser),
    .in_entry_i (in_entry),
    .out_data_o (m_axis_tdata),
    .out_user_o (m_axis_tuser)
  );

endmodule

// File: rtl/tph_checker.sv
// Port-level checks for timed_position_history, bound to the top level.
// Depends only on the top-level ports.
`timescale 1ns / 1ps
module tph_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [63:0] s_axis_tdata,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // a result is never both a query hit and a stored add
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("found and stored both set");

  // anything but a query hit carries zero coordinates
  a_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == 48'd0))
    else $error("non-zero coordinates without a hit");

  // one command at a time: no transfer in the cycle after a transfer
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken back to back");

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

endmodule

bind timed_position_history tph_checker u_tph_checker (.*);
